FILE: rtl/wmd_pkg.sv
// Shared types and constants for the window motion direction block.
// Used by every module of the block but wmd_ram; depends on nothing.
`default_nettype none

package wmd_pkg;

   localparam int HISTORY_DEPTH = 8;
   localparam int COORD_BITS    = 12;

   localparam int PTR_W  = $clog2(HISTORY_DEPTH);
   localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
   localparam int DIFF_W = COORD_BITS + 1;
   localparam int SQ_W   = 2 * COORD_BITS;
   localparam int LEN_W  = 2 * COORD_BITS + 1;
   localparam int SUB_W  = 2 * COORD_BITS + 2;

   // Squared unit component d*d*2^28/len2 never exceeds 2^28.
   localparam int QUO_BITS = 29;
   localparam int QUO_W    = QUO_BITS + 1;
   localparam int ROOT_W   = 15;
   localparam int CNT_W    = $clog2(QUO_BITS + 1);
   localparam int DIR_W    = 16;

   localparam logic signed [DIR_W-1:0] DIR_ONE = 16'sd16384;

   typedef enum logic [1:0] {
      ST_FILLING   = 2'd0,
      ST_NEW       = 2'd1,
      ST_NO_MOTION = 2'd2
   } status_type;

   typedef struct packed {
      logic                     start;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
   } eng_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [DIR_W-1:0] dir_x;
      logic signed [DIR_W-1:0] dir_y;
   } eng_rsp_type;

endpackage

`default_nettype wire

FILE: rtl/window_motion_direction_core.sv
// Top level: position history, handshakes and result register of the
// motion direction block. Uses wmd_pkg, wmd_ram and wmd_engine.
//
//   channel | dir | ports                                | content
//   req     | in  | req_tvalid, req_tready, req_tdata    | pos_x, pos_y
//   rsp     | out | rsp_tvalid, rsp_tready, rsp_tdata,   | dir_x, dir_y; status
//           |     | rsp_tuser                            |
//
// While the history fills, an accepted beat goes straight to the emit state.
// Once full, a zero displacement goes via the read state to emit; a new direction
// is set by 29 division steps plus 15 square-root steps per component, all on
// one shared subtractor. One item is in work at a time; req_tready is low
// until its result sits in the output register, which a stalled rsp holds.
// Reset is synchronous and clears history fill, pointer and held direction.
`default_nettype none

module window_motion_direction_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [11:0] pos_x, [23:12] pos_y
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,   // [15:0] dir_x, [31:16] dir_y
   output logic      [1:0]  rsp_tuser    // [1:0] status
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_CALC,
      S_EMIT
   } top_state_type;

   localparam int C = wmd_pkg::COORD_BITS;

   top_state_type state_ff, state_in;

   logic [wmd_pkg::PTR_W-1:0]  wp_ff, wp_in;
   logic [wmd_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic [C-1:0]               new_x_ff, new_x_in, new_y_ff, new_y_in;
   logic signed [wmd_pkg::DIR_W-1:0] held_x_ff, held_x_in, held_y_ff, held_y_in;
   wmd_pkg::status_type        status_ff, status_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [31:0]                rsp_data_ff, rsp_data_in;
   logic [1:0]                 rsp_user_ff, rsp_user_in;

   logic                       accept;
   logic [wmd_pkg::PTR_W-1:0]  wp_next;
   logic                       full_after;
   logic [2*C-1:0]             rd_data;
   logic signed [wmd_pkg::DIFF_W-1:0] dx, dy;
   wmd_pkg::eng_req_type       eng_req;
   wmd_pkg::eng_rsp_type       eng_rsp;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;

   assign wp_next = (wp_ff == wmd_pkg::PTR_W'(wmd_pkg::HISTORY_DEPTH - 1))
                    ? '0 : wp_ff + 1'b1;
   assign full_after = (fill_ff >= wmd_pkg::FILL_W'(wmd_pkg::HISTORY_DEPTH - 1));

   // After the write, the slot past the pointer holds the oldest position.
   wmd_ram #(
      .WIDTH (2 * C),
      .DEPTH (wmd_pkg::HISTORY_DEPTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wp_ff),
      .wr_data ({req_tdata[12 +: C], req_tdata[C-1:0]}),
      .rd_en   (accept),
      .rd_addr (wp_next),
      .rd_data (rd_data)
   );

   assign dx = $signed({1'b0, new_x_ff}) - $signed({1'b0, rd_data[C-1:0]});
   assign dy = $signed({1'b0, new_y_ff}) - $signed({1'b0, rd_data[2*C-1:C]});

   assign eng_req.start = (state_ff == S_READ) && ((dx != '0) || (dy != '0));
   assign eng_req.dx    = dx;
   assign eng_req.dy    = dy;

   wmd_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .eng_req (eng_req),
      .eng_rsp (eng_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      new_x_in     = new_x_ff;
      new_y_in     = new_y_ff;
      held_x_in    = held_x_ff;
      held_y_in    = held_y_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               new_x_in = req_tdata[C-1:0];
               new_y_in = req_tdata[12 +: C];
               wp_in    = wp_next;
               if (fill_ff != wmd_pkg::FILL_W'(wmd_pkg::HISTORY_DEPTH)) begin
                  fill_in = fill_ff + 1'b1;
               end
               if (full_after) begin
                  state_in = S_READ;
               end else begin
                  status_in = wmd_pkg::ST_FILLING;
                  state_in  = S_EMIT;
               end
            end
         end
         S_READ: begin
            if (eng_req.start) begin
               state_in = S_CALC;
            end else begin
               status_in = wmd_pkg::ST_NO_MOTION;
               state_in  = S_EMIT;
            end
         end
         S_CALC: begin
            if (eng_rsp.done) begin
               held_x_in = eng_rsp.dir_x;
               held_y_in = eng_rsp.dir_y;
               status_in = wmd_pkg::ST_NEW;
               state_in  = S_EMIT;
            end
         end
         S_EMIT: begin
            // Wait for the output register to drain before loading it.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {held_y_ff, held_x_ff};
               rsp_user_in  = status_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         fill_ff      <= '0;
         held_x_ff    <= '0;
         held_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         held_x_ff    <= held_x_in;
         held_y_ff    <= held_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      new_x_ff    <= new_x_in;
      new_y_ff    <= new_y_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

FILE: rtl/wmd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module wmd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/wmd_subunit.sv
// Shared subtract-and-compare unit used by both division and square root.
// Depends on wmd_pkg for the operand width.
`default_nettype none

module wmd_subunit (
   input  wire logic [wmd_pkg::SUB_W-1:0] op_a,
   input  wire logic [wmd_pkg::SUB_W-1:0] op_b,
   output logic      [wmd_pkg::SUB_W-1:0] diff,
   output logic                           ge
);

   logic [wmd_pkg::SUB_W:0] wide_diff;

   assign wide_diff = {1'b0, op_a} - {1'b0, op_b};
   assign diff      = wide_diff[wmd_pkg::SUB_W-1:0];
   assign ge        = ~wide_diff[wmd_pkg::SUB_W];

endmodule

`default_nettype wire

FILE: rtl/wmd_engine.sv
// Sequencer that turns a displacement into a Q1.14 unit direction.
// Uses wmd_pkg and one wmd_subunit for restoring division and square root.
`default_nettype none

module wmd_engine (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire wmd_pkg::eng_req_type eng_req,
   output wmd_pkg::eng_rsp_type      eng_rsp
);

   typedef enum logic [2:0] {
      E_IDLE,
      E_SQX,
      E_SQY,
      E_LEN,
      E_DIV_LOAD,
      E_DIV,
      E_SQRT
   } eng_state_type;

   eng_state_type state_ff, state_in;

   logic [wmd_pkg::COORD_BITS-1:0] mag_x_ff, mag_x_in, mag_y_ff, mag_y_in;
   logic                           neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [wmd_pkg::SQ_W-1:0]       sq_x_ff, sq_x_in, sq_y_ff, sq_y_in;
   logic [wmd_pkg::LEN_W-1:0]      len2_ff, len2_in;
   logic [wmd_pkg::LEN_W-1:0]      rem_ff, rem_in;
   logic                           lsb_ff, lsb_in;
   logic [wmd_pkg::QUO_W-1:0]      quo_ff, quo_in;
   logic [wmd_pkg::SUB_W-3:0]      srem_ff, srem_in;
   logic [wmd_pkg::ROOT_W-1:0]     root_ff, root_in;
   logic [wmd_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic                           comp_ff, comp_in;
   logic                           done_ff, done_in;
   logic signed [wmd_pkg::DIR_W-1:0] dir_x_ff, dir_x_in, dir_y_ff, dir_y_in;

   logic [wmd_pkg::COORD_BITS-1:0] mul_op;
   logic [wmd_pkg::SQ_W-1:0]       product;
   logic [wmd_pkg::SQ_W-1:0]       sq_sel;
   logic [wmd_pkg::SUB_W-1:0]      op_a, op_b, diff;
   logic                           ge;
   logic [wmd_pkg::ROOT_W-1:0]     root_final;
   logic signed [wmd_pkg::DIR_W-1:0] dir_pos, dir_neg;
   logic                           div_first;
   logic [wmd_pkg::DIFF_W-1:0]     abs_dx, abs_dy;

   assign abs_dx = eng_req.dx[wmd_pkg::DIFF_W-1] ? -eng_req.dx : eng_req.dx;
   assign abs_dy = eng_req.dy[wmd_pkg::DIFF_W-1] ? -eng_req.dy : eng_req.dy;

   assign mul_op  = (state_ff == E_SQX) ? mag_x_ff : mag_y_ff;
   assign product = mul_op * mul_op;
   assign sq_sel  = comp_ff ? sq_y_ff : sq_x_ff;

   // Only the first division step shifts in the low bit of the square.
   assign div_first = (cnt_ff == wmd_pkg::CNT_W'(wmd_pkg::QUO_BITS));

   always_comb begin
      if (state_ff == E_DIV) begin
         op_a = {rem_ff, div_first & lsb_ff};
         op_b = wmd_pkg::SUB_W'(len2_ff);
      end else begin
         op_a = {srem_ff, quo_ff[wmd_pkg::QUO_W-1 -: 2]};
         op_b = wmd_pkg::SUB_W'({root_ff, 2'b01});
      end
   end

   wmd_subunit u_sub (
      .op_a (op_a),
      .op_b (op_b),
      .diff (diff),
      .ge   (ge)
   );

   assign root_final = {root_ff[wmd_pkg::ROOT_W-2:0], ge};
   assign dir_pos    = wmd_pkg::DIR_W'(root_final);
   assign dir_neg    = -dir_pos;

   always_comb begin
      state_in = state_ff;
      mag_x_in = mag_x_ff;
      mag_y_in = mag_y_ff;
      neg_x_in = neg_x_ff;
      neg_y_in = neg_y_ff;
      sq_x_in  = sq_x_ff;
      sq_y_in  = sq_y_ff;
      len2_in  = len2_ff;
      rem_in   = rem_ff;
      lsb_in   = lsb_ff;
      quo_in   = quo_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;
      cnt_in   = cnt_ff;
      comp_in  = comp_ff;
      done_in  = 1'b0;
      dir_x_in = dir_x_ff;
      dir_y_in = dir_y_ff;

      unique case (state_ff)
         E_IDLE: begin
            if (eng_req.start) begin
               mag_x_in = abs_dx[wmd_pkg::COORD_BITS-1:0];
               mag_y_in = abs_dy[wmd_pkg::COORD_BITS-1:0];
               neg_x_in = eng_req.dx[wmd_pkg::DIFF_W-1];
               neg_y_in = eng_req.dy[wmd_pkg::DIFF_W-1];
               state_in = E_SQX;
            end
         end
         E_SQX: begin
            sq_x_in  = product;
            state_in = E_SQY;
         end
         E_SQY: begin
            sq_y_in  = product;
            state_in = E_LEN;
         end
         E_LEN: begin
            len2_in  = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};
            comp_in  = 1'b0;
            state_in = E_DIV_LOAD;
         end
         E_DIV_LOAD: begin
            // Top bits of d*d*2^28 are already below len2.
            rem_in   = wmd_pkg::LEN_W'(sq_sel >> 1);
            lsb_in   = sq_sel[0];
            quo_in   = '0;
            cnt_in   = wmd_pkg::CNT_W'(wmd_pkg::QUO_BITS);
            state_in = E_DIV;
         end
         E_DIV: begin
            rem_in = ge ? diff[wmd_pkg::LEN_W-1:0] : op_a[wmd_pkg::LEN_W-1:0];
            quo_in = {quo_ff[wmd_pkg::QUO_W-2:0], ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == wmd_pkg::CNT_W'(1)) begin
               srem_in  = '0;
               root_in  = '0;
               cnt_in   = wmd_pkg::CNT_W'(wmd_pkg::ROOT_W);
               state_in = E_SQRT;
            end
         end
         E_SQRT: begin
            srem_in = ge ? diff[wmd_pkg::SUB_W-3:0] : op_a[wmd_pkg::SUB_W-3:0];
            root_in = root_final;
            quo_in  = {quo_ff[wmd_pkg::QUO_W-3:0], 2'b00};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == wmd_pkg::CNT_W'(1)) begin
               if (!comp_ff) begin
                  dir_x_in = neg_x_ff ? dir_neg : dir_pos;
                  comp_in  = 1'b1;
                  state_in = E_DIV_LOAD;
               end else begin
                  dir_y_in = neg_y_ff ? dir_neg : dir_pos;
                  done_in  = 1'b1;
                  state_in = E_IDLE;
               end
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         done_ff  <= 1'b0;
         comp_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         comp_ff  <= comp_in;
      end
      mag_x_ff <= mag_x_in;
      mag_y_ff <= mag_y_in;
      neg_x_ff <= neg_x_in;
      neg_y_ff <= neg_y_in;
      sq_x_ff  <= sq_x_in;
      sq_y_ff  <= sq_y_in;
      len2_ff  <= len2_in;
      rem_ff   <= rem_in;
      lsb_ff   <= lsb_in;
      quo_ff   <= quo_in;
      srem_ff  <= srem_in;
      root_ff  <= root_in;
      cnt_ff   <= cnt_in;
      dir_x_ff <= dir_x_in;
      dir_y_ff <= dir_y_in;
   end

   assign eng_rsp.done  = done_ff;
   assign eng_rsp.dir_x = dir_x_ff;
   assign eng_rsp.dir_y = dir_y_ff;

endmodule

`default_nettype wire

FILE: rtl/wmd_checker.sv
// Port-level checks for window_motion_direction_core, bound to the top level.
// Uses wmd_pkg for status codes and the Q1.14 unit value.
`default_nettype none

module wmd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   // Result register comes out of reset empty.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == wmd_pkg::ST_FILLING || rsp_tuser == wmd_pkg::ST_NEW ||
                      rsp_tuser == wmd_pkg::ST_NO_MOTION))
      else $error("unknown status code");

   // A fresh direction comes from nonzero motion, so it cannot be all zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == wmd_pkg::ST_NEW |-> rsp_tdata != 32'd0)
      else $error("new direction is zero");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         $signed(rsp_tdata[15:0]) <= wmd_pkg::DIR_ONE &&
         $signed(rsp_tdata[15:0]) >= -wmd_pkg::DIR_ONE &&
         $signed(rsp_tdata[31:16]) <= wmd_pkg::DIR_ONE &&
         $signed(rsp_tdata[31:16]) >= -wmd_pkg::DIR_ONE)
      else $error("direction component beyond unit length");

endmodule

bind window_motion_direction_core wmd_checker u_wmd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for window_motion_direction_core: streams tracked positions,
// predicts the unit direction of motion over the sliding window and checks each result beat.
// Depends on wmd_pkg and the core RTL only.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import wmd_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int COORD_MAX      = (1 << COORD_BITS) - 1;

   typedef struct {
      logic signed [DIR_W-1:0] dir_x;
      logic signed [DIR_W-1:0] dir_y;
      status_type              status;
   } direction_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // [11:0] pos_x, [23:12] pos_y
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [15:0] dir_x, [31:16] dir_y
   logic [1:0]  rsp_tuser;         // [1:0] status

   // Position beats waiting to be sent, and directions still owed by the block
   logic [23:0]          position_beats[$];
   direction_result_type expected_dirs[$];

   int  send_idle_pct  = 0;
   int  recv_stall_pct = 0;
   int  error_count    = 0;
   int  quiet_cycles   = 0;
   logic req_taken     = 1'b0;

   // Predictor state: window of positions, fill level, write slot, held direction
   logic [COORD_BITS-1:0]   win_x[HISTORY_DEPTH];
   logic [COORD_BITS-1:0]   win_y[HISTORY_DEPTH];
   int                      win_fill = 0;
   int                      win_slot = 0;
   logic signed [DIR_W-1:0] held_x   = '0;
   logic signed [DIR_W-1:0] held_y   = '0;

   window_motion_direction_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Largest q in [0, one] with q*q*len2 <= d*d*2^28, signed like d
   function automatic logic signed [DIR_W-1:0] unit_component(int d, longint unsigned len2);
      longint unsigned mag, target, lo, hi, mid;
      mag    = (d < 0) ? -d : d;
      target = (mag * mag) << 28;
      lo     = 0;
      hi     = DIR_ONE;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         if (mid * mid * len2 <= target) lo = mid;
         else hi = mid - 1;
      end
      return (d < 0) ? -DIR_W'(lo) : DIR_W'(lo);
   endfunction

   function automatic direction_result_type advance_motion(logic [COORD_BITS-1:0] x,
                                                           logic [COORD_BITS-1:0] y);
      direction_result_type res;
      int dx, dy;
      longint unsigned len2;
      win_x[win_slot] = x;
      win_y[win_slot] = y;
      win_slot = (win_slot + 1) % HISTORY_DEPTH;
      if (win_fill < HISTORY_DEPTH) win_fill++;
      res.status = ST_FILLING;
      if (win_fill >= HISTORY_DEPTH) begin
         // the slot just advanced to holds the oldest position
         dx = int'(x) - int'(win_x[win_slot]);
         dy = int'(y) - int'(win_y[win_slot]);
         if (dx == 0 && dy == 0) begin
            res.status = ST_NO_MOTION;
         end else begin
            len2   = longint'(dx * dx) + longint'(dy * dy);
            held_x = unit_component(dx, len2);
            held_y = unit_component(dy, len2);
            res.status = ST_NEW;
         end
      end
      res.dir_x = held_x;
      res.dir_y = held_y;
      return res;
   endfunction

   // Push one position and remember it for windowed stimulus
   function automatic void send_position(ref logic [23:0] log_q[$], input int x,
                                         input int y);
      log_q.push_back({12'(y), 12'(x)});
      position_beats.push_back({12'(y), 12'(x)});
   endfunction

   task automatic random_phase(ref logic [23:0] log_q[$], input int send_pct,
                               input int stall_pct, input int count);
      int pick, tx, ty, n;
      logic [23:0] last, oldest;
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         n      = log_q.size();
         last   = log_q[n-1];
         oldest = log_q[n-HISTORY_DEPTH+1];
         pick   = $urandom_range(99);
         if (pick < 50) begin
            // drift by a few pixels from the last position
            tx = int'(last[11:0]) + $urandom_range(64) - 32;
            ty = int'(last[23:12]) + $urandom_range(64) - 32;
            tx = (tx < 0) ? 0 : (tx > COORD_MAX) ? COORD_MAX : tx;
            ty = (ty < 0) ? 0 : (ty > COORD_MAX) ? COORD_MAX : ty;
         end else if (pick < 65) begin
            tx = $urandom_range(COORD_MAX);
            ty = $urandom_range(COORD_MAX);
         end else if (pick < 75) begin
            // land back on the oldest position in the window
            tx = oldest[11:0];
            ty = oldest[23:12];
         end else if (pick < 85) begin
            tx = $urandom_range(1) ? int'(oldest[11:0]) : $urandom_range(COORD_MAX);
            ty = (tx == oldest[11:0]) ? $urandom_range(COORD_MAX) : int'(oldest[23:12]);
         end else begin
            tx = $urandom_range(1) ? COORD_MAX : 0;
            ty = $urandom_range(1) ? COORD_MAX : 0;
         end
         send_position(log_q, tx, ty);
      end
      while (position_beats.size() != 0 || expected_dirs.size() != 0) @(posedge clock);
   endtask

   // Driver: change inputs on the falling edge, hold a beat until it is taken
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (req_taken) void'(position_beats.pop_front());
         if (!req_tvalid || req_taken) begin
            if (position_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= position_beats[0];
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor: predict on each accepted position, check each accepted result
   always @(posedge clock) begin : monitor
      direction_result_type want;
      logic req_fire, rsp_fire;
      req_fire = req_tvalid && req_tready;
      rsp_fire = rsp_tvalid && rsp_tready;
      if (reset) begin
         req_taken    <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         req_taken <= req_fire;
         if (req_fire)
            expected_dirs.push_back(advance_motion(req_tdata[11:0], req_tdata[23:12]));
         if (rsp_fire) begin
            if (expected_dirs.size() == 0) begin
               $display("%0t unexpected result beat: dir_x %0d dir_y %0d status %0d", $time,
                        $signed(rsp_tdata[15:0]), $signed(rsp_tdata[31:16]), rsp_tuser);
               error_count++;
            end else begin
               want = expected_dirs.pop_front();
               if (rsp_tdata[15:0] !== want.dir_x) begin
                  $display("%0t dir_x mismatch: expected %0d, actual %0d", $time,
                           want.dir_x, $signed(rsp_tdata[15:0]));
                  error_count++;
               end
               if (rsp_tdata[31:16] !== want.dir_y) begin
                  $display("%0t dir_y mismatch: expected %0d, actual %0d", $time,
                           want.dir_y, $signed(rsp_tdata[31:16]));
                  error_count++;
               end
               if (rsp_tuser !== want.status) begin
                  $display("%0t status mismatch: expected %0d, actual %0d", $time,
                           want.status, rsp_tuser);
                  error_count++;
               end
            end
         end
         if (req_fire || rsp_fire) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no beat for %0d cycles", $time, quiet_cycles);
            $display("tb_top failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin : stimulus
      logic [23:0] sent[$];

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: fill the window, then zero, axis-aligned and diagonal moves, many at the extremes
      send_position(sent, 0, 0);
      send_position(sent, COORD_MAX, COORD_MAX);
      send_position(sent, 0, COORD_MAX);
      send_position(sent, COORD_MAX, 0);
      send_position(sent, 1, 2);
      send_position(sent, 2048, 2048);
      send_position(sent, 100, 200);
      send_position(sent, 0, 0);
      send_position(sent, COORD_MAX, COORD_MAX);
      send_position(sent, COORD_MAX, COORD_MAX);
      send_position(sent, 0, COORD_MAX);
      send_position(sent, 1, 0);
      send_position(sent, 0, 0);
      send_position(sent, 100, COORD_MAX);
      send_position(sent, 0, COORD_MAX);
      send_position(sent, COORD_MAX, COORD_MAX);
      send_position(sent, 0, COORD_MAX);
      send_position(sent, 1, COORD_MAX - 1);

      random_phase(sent, 0, 0, 132);
      random_phase(sent, 50, 0, 133);
      random_phase(sent, 0, 50, 133);
      random_phase(sent, 12, 12, 133);

      // let any trailing beat drain before judging
      repeat (150) @(posedge clock);
      if (error_count == 0) $display("tb_top passed");
      else $display("tb_top failed");
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
rtl/wmd_pkg.sv
rtl/wmd_ram.sv
rtl/wmd_subunit.sv
rtl/wmd_engine.sv
rtl/window_motion_direction_core.sv
rtl/wmd_checker.sv
bench/tb_top.sv
